/* sv/hms_pkg.sv */
// hms_pkg: request, response and state types, constants and codes
// for the hours/minutes/seconds clock. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hms_pkg;

   localparam int unsigned PeriodWidth = 14;
   localparam int unsigned HoldWidth   = 4;
   localparam int unsigned CsrWidth    = PeriodWidth;

   localparam logic [PeriodWidth-1:0] PeriodReset = 14'd15105;
   localparam logic [HoldWidth-1:0]   HoldReset   = 4'd6;
   localparam logic [HoldWidth-1:0]   BothMax     = 4'd15;
   localparam logic [5:0]             LastSec     = 6'd59;
   localparam logic [5:0]             LastMin     = 6'd59;
   localparam logic [4:0]             LastHour    = 5'd23;

   typedef enum logic {
      FUNC_TICK   = 1'b0,
      FUNC_SAMPLE = 1'b1
   } func_type;

   typedef enum logic {
      CSR_PERIOD = 1'b0,
      CSR_HOLD   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic func;
      logic hour_button;
      logic minute_button;
      logic sleep_button;
   } req_type;

   typedef struct packed {
      logic [5:0] sec_value;
      logic [5:0] min_value;
      logic [4:0] hour_value;
      logic       asleep;
      logic [5:0] minute_leds;
      logic [4:0] hour_leds;
      logic       second_led;
   } rsp_type;

   typedef struct packed {
      logic [PeriodWidth-1:0] period;
      logic [HoldWidth-1:0]   hold;
   } cfg_type;

   typedef struct packed {
      logic [5:0]             sec;
      logic [5:0]             min;
      logic [4:0]             hour;
      logic [PeriodWidth-1:0] drift;
      logic                   sleeping;
      logic                   blink;
      logic                   minute_held;
      logic                   hour_held;
      logic                   sleep_held;
      logic [HoldWidth-1:0]   both;
      logic                   await_release;
   } state_type;

endpackage

`default_nettype wire

/* sv/hms_step.sv */
// hms_step: next clock/button state and the response for one request.
// Depends on hms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hms_step (
   input  hms_pkg::state_type cur,
   input  hms_pkg::req_type   req,
   input  hms_pkg::cfg_type   cfg,
   output hms_pkg::state_type nxt,
   output hms_pkg::rsp_type   rsp
);
   import hms_pkg::*;

   logic [PeriodWidth-1:0] drift_inc;
   logic [5:0]             min_inc;
   logic [4:0]             hour_inc;
   logic [HoldWidth-1:0]   both_sat;
   logic                   hr, mn, sl;

   assign hr        = req.hour_button;
   assign mn        = req.minute_button;
   assign sl        = req.sleep_button;
   assign drift_inc = cur.drift + 1'b1;
   assign min_inc   = (cur.min == LastMin) ? 6'd0 : cur.min + 6'd1;
   assign hour_inc  = (cur.hour == LastHour) ? 5'd0 : cur.hour + 5'd1;
   assign both_sat  = (cur.both == BothMax) ? BothMax : cur.both + 1'b1;

   always_comb begin
      nxt = cur;
      if (req.func == FUNC_TICK) begin
         nxt.blink = ~cur.blink;
         nxt.drift = drift_inc;
         if (drift_inc == cfg.period) begin
            nxt.drift = '0;
         end else if (cur.sec == LastSec) begin
            nxt.sec = 6'd0;
            nxt.min = min_inc;
            if (cur.min == LastMin) begin
               nxt.hour = hour_inc;
            end
         end else begin
            nxt.sec = cur.sec + 6'd1;
         end
      end else if (!(cur.await_release && (hr || mn))) begin
         nxt.await_release = 1'b0;
         if (sl && !cur.sleep_held) begin
            nxt.sleeping = ~cur.sleeping;
         end
         nxt.sleep_held = sl;
         if (hr && mn) begin
            nxt.both = both_sat;
            if (both_sat > cfg.hold) begin
               if (nxt.sleeping) begin
                  nxt.sleeping = 1'b0;
               end else begin
                  nxt.sec  = 6'd0;
                  nxt.min  = 6'd0;
                  nxt.hour = 5'd0;
               end
               nxt.minute_held   = 1'b0;
               nxt.hour_held     = 1'b0;
               nxt.both          = '0;
               nxt.await_release = 1'b1;
            end
         end else begin
            nxt.both = '0;
            if (mn && !cur.minute_held) begin
               nxt.minute_held = 1'b1;
               if (nxt.sleeping) begin
                  nxt.sleeping = 1'b0;
               end else begin
                  nxt.min = min_inc;
               end
            end else if (!mn) begin
               nxt.minute_held = 1'b0;
            end
            if (hr && !cur.hour_held) begin
               nxt.hour_held = 1'b1;
               if (nxt.sleeping) begin
                  nxt.sleeping = 1'b0;
               end else begin
                  nxt.hour = hour_inc;
               end
            end else if (!hr) begin
               nxt.hour_held = 1'b0;
            end
         end
      end
   end

   always_comb begin
      rsp.sec_value   = nxt.sec;
      rsp.min_value   = nxt.min;
      rsp.hour_value  = nxt.hour;
      rsp.asleep      = nxt.sleeping;
      rsp.minute_leds = nxt.sleeping ? 6'd0 : nxt.min;
      rsp.hour_leds   = nxt.sleeping ? 5'd0 : nxt.hour;
      rsp.second_led  = nxt.blink & ~nxt.sleeping;
   end

endmodule

`default_nettype wire

/* sv/hms_clock_with_set_buttons.sv */
// hms_clock_with_set_buttons: top level, state and config registers and
// the response register. Depends on hms_pkg and hms_step.
//
//  channel  ports                           direction
//  req      req_valid/req_ready/req_data    in: tick or button sample
//  rsp      rsp_valid/rsp_ready/rsp_data    out: time and LED levels
//  csr      csr_we/csr_index/csr_wdata      in: period and hold registers
//
// One request per cycle unless a response stalls; the response appears
// in the response register in the cycle after the request is taken.
// req_ready is high whenever that register is empty or being drained.
// Synchronous reset clears time and flags and loads the config defaults.
`timescale 1ns / 1ps
`default_nettype none

module hms_clock_with_set_buttons (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  hms_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output hms_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [hms_pkg::CsrWidth-1:0]    csr_wdata
);
   import hms_pkg::*;

   state_type state_ff, state_in;
   cfg_type   cfg_ff;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff;
   logic      take;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   hms_step u_step (
      .cur (state_ff),
      .req (req_data),
      .cfg (cfg_ff),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         cfg_ff       <= '{period: PeriodReset, hold: HoldReset};
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            state_ff <= state_in;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_PERIOD: cfg_ff.period <= csr_wdata[PeriodWidth-1:0];
               CSR_HOLD:   cfg_ff.hold   <= csr_wdata[HoldWidth-1:0];
               default:    cfg_ff        <= cfg_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   a_take_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid)
      else $error("accepted request produced no response");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.sec <= LastSec && state_ff.min <= LastMin && state_ff.hour <= LastHour)
      else $error("time count out of range");

   a_blank_asleep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.asleep |->
         rsp_data.minute_leds == 6'd0 && rsp_data.hour_leds == 5'd0 && !rsp_data.second_led)
      else $error("LEDs lit while asleep");

   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_data.sec_value == state_ff.sec && rsp_data.asleep == state_ff.sleeping)
      else $error("response does not match stored state");
`endif

endmodule

`default_nettype wire
